FILE: rtl/midi_clock_tempo_tracker_top_macros.svh
// Assertion shorthands for the tempo tracker. Each expands to a concurrent
// assertion clocked on clk and disabled while rst_n is low.
`ifndef MIDI_CLOCK_TEMPO_TRACKER_TOP_MACROS_SVH
`define MIDI_CLOCK_TEMPO_TRACKER_TOP_MACROS_SVH

`define MCTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define MCTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define MCTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mctt_pkg.sv
`default_nettype none

package mctt_pkg;

  localparam int TS_IN_W       = 32;
  localparam int DIV_W         = 18;
  localparam int DIVISOR_W     = 16;
  localparam int CNT_W         = 5;
  localparam int BPM_W         = 8;
  localparam int DUR_W         = 16;
  localparam int STEP_W        = 5;

  localparam int TICKS_PER_BEAT = 24;
  localparam int MS_PER_MINUTE  = 60000;
  localparam int BEATS_PER_BAR  = 4;
  localparam int MS_PER_BAR     = MS_PER_MINUTE * BEATS_PER_BAR;
  localparam int BPM_MAX        = 255;
  localparam int DUR_MAX        = 65535;

  localparam logic [1:0] PR_EVERY_24 = 2'd0;
  localparam logic [1:0] PR_EVERY_12 = 2'd1;
  localparam logic [1:0] PR_EVERY_6  = 2'd2;
  localparam logic [1:0] PR_EVERY_3  = 2'd3;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

FILE: rtl/midi_clock_tempo_tracker_top.sv
// MIDI clock tempo tracker.
// Input channel: one MIDI clock tick per transfer on in_valid/in_ready, carrying
// its millisecond timestamp. Output channel: exactly one result per input
// tick on out_valid/out_ready, holding pulse, beat_done, bpm, bar duration
// and the division error flag. cfg_wr_en writes the 2-bit pulse rate select
// in the same cycle, with no handshake; write it only while the block is idle.
// A tick that does not close a beat goes from S_IDLE straight to S_OUT, which
// loads the output register and raises out_valid. A tick that closes a beat
// passes S_PERIOD, which forms the period, and S_CHECK, which checks it; one
// bit-serial divider then runs two passes from request to quotient,
// 60000 / period and then 240000 / bpm, and S_OUT loads the result; a period
// of zero or over 60000 skips both passes and sets the division error flag.
// One tick is processed at a time; in_ready is high only while no tick is in
// flight, so a new tick is accepted only once the last one has left S_OUT.
// A finished result sits in the output register, and the next tick may be
// accepted while it waits; if the receiver stalls, that next result is held
// internally until the output register frees up, and in_ready stays low.
// Synchronous active-low reset clears the tick count, both timestamp slots,
// the slot select, bpm, bar duration and the pulse rate select.
`default_nettype none
`include "midi_clock_tempo_tracker_top_macros.svh"

module midi_clock_tempo_tracker_top #(
  parameter int TIMESTAMP_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [1:0]                    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mctt_pkg::TS_IN_W-1:0]  in_timestamp_ms,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_pulse,
  output logic                               out_beat_done,
  output logic [mctt_pkg::BPM_W-1:0]         out_bpm,
  output logic [mctt_pkg::DUR_W-1:0]         out_bar_duration_ms,
  output logic                               out_div_error
);
  import mctt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PERIOD,
    S_CHECK,
    S_DIV_BPM,
    S_DIV_BAR,
    S_OUT
  } state_t;

  state_t                     state_r;
  logic [1:0]                 pulse_rate_r;
  logic [CNT_W-1:0]           tick_count_r;
  logic [TIMESTAMP_WIDTH-1:0] slot_r [2];
  logic                       slot_sel_r;
  logic [TIMESTAMP_WIDTH-1:0] period_r;
  logic [BPM_W-1:0]           bpm_r;
  logic [BPM_W-1:0]           bpm_pend_r;
  logic [DUR_W-1:0]           dur_r;
  logic                       res_pulse_r;
  logic                       res_beat_r;
  logic                       res_err_r;
  div_req_t                   div_req_r;

  logic                       out_valid_r;
  logic                       out_pulse_r;
  logic                       out_beat_r;
  logic [BPM_W-1:0]           out_bpm_r;
  logic [DUR_W-1:0]           out_dur_r;
  logic                       out_err_r;

  logic                       in_fire;
  logic [CNT_W-1:0]           count_inc;
  logic                       pulse_hit;
  logic                       beat_hit;
  logic [TIMESTAMP_WIDTH-1:0] ts;
  logic [TIMESTAMP_WIDTH:0]   diff_ab;
  logic [TIMESTAMP_WIDTH-1:0] diff_ba;
  logic                       period_bad;
  logic                       in_div_state;
  logic                       div_done;
  logic [DIV_W-1:0]           div_quo;
  logic [BPM_W-1:0]           bpm_sat;
  logic [DUR_W-1:0]           dur_sat;

  mctt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign ts        = TIMESTAMP_WIDTH'(in_timestamp_ms);
  assign count_inc = tick_count_r + CNT_W'(1);
  assign beat_hit  = (count_inc >= CNT_W'(TICKS_PER_BEAT));

  always_comb begin
    case (pulse_rate_r)
      PR_EVERY_24: pulse_hit = (count_inc == CNT_W'(24));
      PR_EVERY_12: pulse_hit = count_inc inside {5'd12, 5'd24};
      PR_EVERY_6:  pulse_hit = count_inc inside {5'd6, 5'd12, 5'd18, 5'd24};
      default:     pulse_hit = count_inc inside {5'd3, 5'd6, 5'd9, 5'd12,
                                                 5'd15, 5'd18, 5'd21, 5'd24};
    endcase
  end

  assign diff_ab = {1'b0, slot_r[0]} - {1'b0, slot_r[1]};
  assign diff_ba = slot_r[1] - slot_r[0];

  assign period_bad   = (period_r == '0) || (period_r > TIMESTAMP_WIDTH'(MS_PER_MINUTE));
  assign in_div_state = (state_r == S_DIV_BPM) || (state_r == S_DIV_BAR);

  assign bpm_sat = (div_quo > DIV_W'(BPM_MAX)) ? BPM_W'(BPM_MAX) : div_quo[BPM_W-1:0];
  assign dur_sat = (div_quo > DIV_W'(DUR_MAX)) ? DUR_W'(DUR_MAX) : div_quo[DUR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pulse_rate_r <= PR_EVERY_24;
      tick_count_r <= '0;
      slot_r[0]    <= '0;
      slot_r[1]    <= '0;
      slot_sel_r   <= 1'b0;
      bpm_r        <= '0;
      dur_r        <= '0;
      div_req_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      div_req_r.start <= ((state_r == S_CHECK) && !period_bad) ||
                         ((state_r == S_DIV_BPM) && div_done);
      out_valid_r     <= (state_r == S_OUT) || (out_valid_r && !out_ready);
      if (cfg_wr_en) begin
        pulse_rate_r <= cfg_wr_data;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            res_pulse_r <= pulse_hit;
            res_beat_r  <= beat_hit;
            res_err_r   <= 1'b0;
            if (beat_hit) begin
              tick_count_r       <= '0;
              slot_r[slot_sel_r] <= ts;
              slot_sel_r         <= ~slot_sel_r;
              state_r            <= S_PERIOD;
            end else begin
              tick_count_r <= count_inc;
              state_r      <= S_OUT;
            end
          end
        end
        S_PERIOD: begin
          period_r <= diff_ab[TIMESTAMP_WIDTH] ? diff_ba : diff_ab[TIMESTAMP_WIDTH-1:0];
          state_r  <= S_CHECK;
        end
        S_CHECK: begin
          if (period_bad) begin
            res_err_r <= 1'b1;
            state_r   <= S_OUT;
          end else begin
            div_req_r.dividend <= DIV_W'(MS_PER_MINUTE);
            div_req_r.divisor  <= period_r[DIVISOR_W-1:0];
            state_r            <= S_DIV_BPM;
          end
        end
        S_DIV_BPM: begin
          if (div_done) begin
            bpm_pend_r         <= bpm_sat;
            div_req_r.dividend <= DIV_W'(MS_PER_BAR);
            div_req_r.divisor  <= DIVISOR_W'(bpm_sat);
            state_r            <= S_DIV_BAR;
          end
        end
        S_DIV_BAR: begin
          if (div_done) begin
            bpm_r   <= bpm_pend_r;
            dur_r   <= dur_sat;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_pulse_r <= res_pulse_r;
            out_beat_r  <= res_beat_r;
            out_bpm_r   <= bpm_r;
            out_dur_r   <= dur_r;
            out_err_r   <= res_err_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pulse           = out_pulse_r;
  assign out_beat_done       = out_beat_r;
  assign out_bpm             = out_bpm_r;
  assign out_bar_duration_ms = out_dur_r;
  assign out_div_error       = out_err_r;

  `MCTT_ASSERT(a_tick_range, tick_count_r < CNT_W'(TICKS_PER_BEAT), "tick count out of range")
  `MCTT_ASSERT_IMP(a_div_done_state, div_done, in_div_state, "divider done outside a divide")
  `MCTT_ASSERT_NXT(a_plain_tick, in_fire && !beat_hit, state_r == S_OUT, "plain tick skipped output")
  `MCTT_ASSERT_IMP(a_err_on_beat, out_valid_r && out_err_r, out_beat_r, "error without a beat")

endmodule

`default_nettype wire

FILE: rtl/mctt_div.sv
`default_nettype none

module mctt_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mctt_pkg::div_req_t       req,
  output logic                          done,
  output logic [mctt_pkg::DIV_W-1:0]    quotient
);
  import mctt_pkg::*;

  // Restoring divider: one quotient bit per cycle, dividend shifted in MSB first.
  logic                 busy_r;
  logic                 done_r;
  logic [STEP_W-1:0]    step_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] dvs_r;

  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_sub;
  logic                 q_bit;

  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign q_bit   = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DIV_W-2:0], q_bit};
        rem_r <= q_bit ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire
